/* src/tcw_pkg.sv */
// ----------------------------------------------------------------------------
// tcw_pkg: text console writer shared definitions
// Codes, control word layout and the sequencer program.
// ----------------------------------------------------------------------------
package tcw_pkg;

  localparam logic [7:0] CODE_NEWLINE   = 8'd10;
  localparam logic [7:0] CODE_BACKSPACE = 8'd8;
  localparam logic [7:0] CODE_SPACE     = 8'd32;
  localparam logic [7:0] RESET_ATTR     = 8'd15;

  typedef enum logic [1:0] {
    OP_PUT   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    ST_INIT      = 4'd0,
    ST_FETCH     = 4'd1,
    ST_PUT       = 4'd2,
    ST_CLR       = 4'd3,
    ST_READ      = 4'd4,
    ST_NOP       = 4'd5,
    ST_READ_OUT  = 4'd6,
    ST_CLR_DONE  = 4'd7,
    ST_SCR_PRIME = 4'd8,
    ST_SCR_COPY  = 4'd9,
    ST_SCR_LAST  = 4'd10,
    ST_SCR_BLANK = 4'd11,
    ST_SCR_DONE  = 4'd12
  } step_t;

  typedef enum logic [2:0] {
    W_NONE,
    W_PUT,
    W_BLANK,
    W_RST,
    W_COPY
  } wsel_t;

  typedef enum logic [1:0] {
    R_NONE,
    R_INDEX,
    R_COPY
  } rsel_t;

  typedef enum logic {
    L_LAST,
    L_COPY_END
  } lim_t;

  typedef enum logic [1:0] {
    C_HOLD,
    C_PUT,
    C_HOME
  } cur_t;

  typedef enum logic [2:0] {
    J_NEXT,
    J_GOTO,
    J_LOOP,
    J_DISPATCH,
    J_PUT
  } jmp_t;

  typedef struct packed {
    logic  rdy;
    logic  emit;
    logic  out_cell;
    logic  out_scr;
    wsel_t wsel;
    rsel_t rsel;
    logic  inc;
    lim_t  lim;
    cur_t  cur;
    jmp_t  jmp;
    step_t target;
  } ctrl_t;

  function automatic ctrl_t ctrl_rom(step_t s);
    ctrl_t c;
    c = '{rdy: 1'b0, emit: 1'b0, out_cell: 1'b0, out_scr: 1'b0, wsel: W_NONE,
          rsel: R_NONE, inc: 1'b0, lim: L_LAST, cur: C_HOLD, jmp: J_NEXT,
          target: ST_FETCH};
    unique case (s)
      ST_INIT: begin
        c.wsel = W_RST; c.inc = 1'b1; c.jmp = J_LOOP; c.target = ST_FETCH;
      end
      ST_FETCH: begin
        c.rdy = 1'b1; c.jmp = J_DISPATCH; c.target = ST_PUT;
      end
      ST_PUT: begin
        c.emit = 1'b1; c.wsel = W_PUT; c.cur = C_PUT; c.jmp = J_PUT;
        c.target = ST_SCR_PRIME;
      end
      ST_CLR: begin
        c.wsel = W_BLANK; c.inc = 1'b1; c.jmp = J_LOOP; c.target = ST_CLR_DONE;
      end
      ST_READ: begin
        c.rsel = R_INDEX; c.jmp = J_GOTO; c.target = ST_READ_OUT;
      end
      ST_NOP: begin
        c.emit = 1'b1; c.jmp = J_GOTO; c.target = ST_FETCH;
      end
      ST_READ_OUT: begin
        c.emit = 1'b1; c.out_cell = 1'b1; c.jmp = J_GOTO; c.target = ST_FETCH;
      end
      ST_CLR_DONE: begin
        c.emit = 1'b1; c.cur = C_HOME; c.jmp = J_GOTO; c.target = ST_FETCH;
      end
      ST_SCR_PRIME: begin
        c.rsel = R_COPY; c.inc = 1'b1; c.jmp = J_NEXT;
      end
      ST_SCR_COPY: begin
        c.wsel = W_COPY; c.rsel = R_COPY; c.inc = 1'b1; c.lim = L_COPY_END;
        c.jmp = J_LOOP; c.target = ST_SCR_LAST;
      end
      ST_SCR_LAST: begin
        c.wsel = W_COPY; c.jmp = J_NEXT;
      end
      ST_SCR_BLANK: begin
        c.wsel = W_BLANK; c.inc = 1'b1; c.jmp = J_LOOP; c.target = ST_SCR_DONE;
      end
      ST_SCR_DONE: begin
        c.emit = 1'b1; c.out_scr = 1'b1; c.jmp = J_GOTO; c.target = ST_FETCH;
      end
      default: begin
        c.jmp = J_GOTO; c.target = ST_FETCH;
      end
    endcase
    return c;
  endfunction

endpackage

/* src/tcw_if.sv */
// ----------------------------------------------------------------------------
// tcw_if: text console writer channels
// Valid/ready channels for input words and result words.
// ----------------------------------------------------------------------------
interface tcw_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [7:0]  character;
  logic [7:0]  attribute;
  logic [10:0] cell_index;

  modport source (output valid, output operation, output character,
                  output attribute, output cell_index, input ready);
  modport sink (input valid, input operation, input character,
                input attribute, input cell_index, output ready);
endinterface

interface tcw_out_if;
  logic        valid;
  logic        ready;
  logic [10:0] cursor_position;
  logic [7:0]  cell_character;
  logic [7:0]  cell_attribute;
  logic        scrolled;

  modport source (output valid, output cursor_position, output cell_character,
                  output cell_attribute, output scrolled, input ready);
  modport sink (input valid, input cursor_position, input cell_character,
                input cell_attribute, input scrolled, output ready);
endinterface

/* src/text_console_writer_unit.sv */
// ----------------------------------------------------------------------------
// text_console_writer_unit: text-mode console engine
// Microcoded sequencer over a ROWS x COLUMNS screen store of character and
// attribute cells: put, newline, backspace, scroll, clear and cell read.
//
//   channel  dir  words
//   in_ch    in   operation, character, attribute, cell_index
//   out_ch   out  cursor_position, cell_character, cell_attribute, scrolled
//   cfg      in   cfg_wr_en / cfg_wr_data (blank_attribute)
//
// Put, newline, backspace and unused operation run a fetch step, then a put or
// no-op step. Read adds a store read before its result. Clear walks every cell,
// then emits. A scroll copies each row up through the store's separate read and write ports, then blanks the last row.
// After reset a clearing pass over all ROWS*COLUMNS cells runs; in_ch.ready is low.
// A result waits in the output register while the next word is taken; the
// next emitting step holds until that register is free.
// ----------------------------------------------------------------------------
module text_console_writer_unit #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_wr_en,
  input  logic [7:0]    cfg_wr_data,
  tcw_in_if.sink        in_ch,
  tcw_out_if.source     out_ch
);

  localparam int CELLS = ROWS * COLUMNS;
  localparam int AW    = $clog2(CELLS);
  localparam int CLW   = $clog2(COLUMNS);
  localparam int RWD   = (ROWS > 2) ? $clog2(ROWS) : 1;
  localparam logic [AW-1:0] LAST_ADDR = AW'(CELLS - 1);
  localparam logic [AW-1:0] COPY_END  = AW'((ROWS - 1) * COLUMNS - 1);

  tcw_pkg::step_t pc, pc_next;
  tcw_pkg::ctrl_t cw;

  logic [7:0]     blank_attr;
  logic [CLW-1:0] col, col_next;
  logic [RWD-1:0] row, row_next;
  logic [AW-1:0]  addr;
  logic [1:0]     op_q;
  logic [7:0]     ch_q;
  logic [7:0]     attr_q;
  logic [10:0]    idx_q;
  logic           rd_ok;

  logic           accept, go, out_load, scroll_need, idx_in_range, at_lim;
  logic [AW-1:0]  put_addr, lin;
  logic [CLW-1:0] put_col;
  logic           put_we;
  logic           we, re;
  logic [AW-1:0]  waddr, raddr;
  logic [15:0]    wdata, rdata;

  assign cw           = tcw_pkg::ctrl_rom(pc);
  assign in_ch.ready  = cw.rdy;
  assign accept       = in_ch.valid && cw.rdy;
  assign go           = !cw.emit || !out_ch.valid || out_ch.ready;
  assign idx_in_range = {21'd0, idx_q} < 32'(CELLS);
  assign at_lim       = (cw.lim == tcw_pkg::L_LAST) ? (addr == LAST_ADDR)
                                                    : (addr == COPY_END);
  assign out_load     = go && cw.emit && !(cw.jmp == tcw_pkg::J_PUT && scroll_need);

  // put decode
  always_comb begin
    logic row_inc;
    row_inc     = 1'b0;
    put_we      = 1'b1;
    put_col     = col;
    col_next    = col;
    row_next    = row;
    scroll_need = 1'b0;
    if (ch_q == tcw_pkg::CODE_NEWLINE) begin
      put_we   = 1'b0;
      col_next = '0;
      row_inc  = 1'b1;
    end else if (ch_q == tcw_pkg::CODE_BACKSPACE) begin
      put_col = col - CLW'(1);
      if (col != '0) begin
        col_next = put_col;
      end else begin
        put_we = 1'b0;
      end
    end else if (col == CLW'(COLUMNS - 1)) begin
      col_next = '0;
      row_inc  = 1'b1;
    end else begin
      col_next = col + CLW'(1);
    end
    if (row_inc) begin
      if (row == RWD'(ROWS - 1)) begin
        scroll_need = 1'b1;
      end else begin
        row_next = row + RWD'(1);
      end
    end
    if (cw.cur == tcw_pkg::C_HOME) begin
      col_next = '0;
      row_next = '0;
    end else if (cw.cur == tcw_pkg::C_HOLD) begin
      col_next = col;
      row_next = row;
    end
  end

  assign put_addr = AW'(row) * AW'(COLUMNS) + AW'(put_col);
  assign lin      = AW'(row_next) * AW'(COLUMNS) + AW'(col_next);

  // next step
  always_comb begin
    pc_next = pc;
    if (go) begin
      unique case (cw.jmp)
        tcw_pkg::J_NEXT:     pc_next = tcw_pkg::step_t'(pc + 4'd1);
        tcw_pkg::J_GOTO:     pc_next = cw.target;
        tcw_pkg::J_LOOP:     pc_next = at_lim ? cw.target : pc;
        tcw_pkg::J_DISPATCH: pc_next = accept
                               ? tcw_pkg::step_t'(cw.target + {2'd0, in_ch.operation})
                               : pc;
        tcw_pkg::J_PUT:      pc_next = scroll_need ? cw.target : tcw_pkg::ST_FETCH;
        default:             pc_next = tcw_pkg::ST_FETCH;
      endcase
    end
  end

  // datapath control
  always_comb begin
    we    = 1'b0;
    waddr = addr;
    wdata = {blank_attr, tcw_pkg::CODE_SPACE};
    re    = 1'b0;
    raddr = addr + AW'(COLUMNS);
    unique case (cw.wsel)
      tcw_pkg::W_PUT: begin
        we    = go && put_we;
        waddr = put_addr;
        wdata = (ch_q == tcw_pkg::CODE_BACKSPACE) ? {attr_q, tcw_pkg::CODE_SPACE}
                                                  : {attr_q, ch_q};
      end
      tcw_pkg::W_BLANK: we = 1'b1;
      tcw_pkg::W_RST: begin
        we    = 1'b1;
        wdata = {tcw_pkg::RESET_ATTR, tcw_pkg::CODE_SPACE};
      end
      tcw_pkg::W_COPY: begin
        we    = 1'b1;
        waddr = addr - AW'(1);
        wdata = rdata;
      end
      default: we = 1'b0;
    endcase
    unique case (cw.rsel)
      tcw_pkg::R_INDEX: begin
        re    = idx_in_range;
        raddr = AW'(idx_q);
      end
      tcw_pkg::R_COPY: re = 1'b1;
      default:         re = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc         <= tcw_pkg::ST_INIT;
      addr       <= '0;
      col        <= '0;
      row        <= '0;
      blank_attr <= tcw_pkg::RESET_ATTR;
      out_ch.valid <= 1'b0;
    end else begin
      pc <= pc_next;
      if (cfg_wr_en) begin
        blank_attr <= cfg_wr_data;
      end
      if (accept) begin
        addr <= '0;
      end else if (go && cw.inc) begin
        addr <= addr + AW'(1);
      end
      if (go) begin
        col <= col_next;
        row <= row_next;
      end
      if (out_load) begin
        out_ch.valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_q   <= in_ch.operation;
      ch_q   <= in_ch.character;
      attr_q <= in_ch.attribute;
      idx_q  <= in_ch.cell_index;
    end
    if (cw.rsel == tcw_pkg::R_INDEX) begin
      rd_ok <= idx_in_range;
    end
    if (out_load) begin
      out_ch.cursor_position <= 11'(lin);
      out_ch.cell_character  <= (cw.out_cell && rd_ok) ? rdata[7:0] : 8'd0;
      out_ch.cell_attribute  <= (cw.out_cell && rd_ok) ? rdata[15:8] : 8'd0;
      out_ch.scrolled        <= cw.out_scr;
    end
  end

  tcw_screen_ram #(
    .DEPTH (CELLS),
    .AW    (AW),
    .DW    (16)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  a_accept_leaves_fetch: assert property (@(posedge clk) disable iff (rst)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("input taken twice in a row");

  a_reset_blocks_input: assert property (@(posedge clk)
    rst |=> !in_ch.ready)
    else $error("input taken during clearing pass");

  a_no_write_on_fetch: assert property (@(posedge clk) disable iff (rst)
    in_ch.ready |-> !we)
    else $error("store written while waiting for a word");

  a_op_latched: assert property (@(posedge clk) disable iff (rst)
    pc == tcw_pkg::ST_READ |-> op_q == tcw_pkg::OP_READ)
    else $error("read step without read word");

endmodule

/* src/tcw_screen_ram.sv */
// ----------------------------------------------------------------------------
// tcw_screen_ram: screen cell store
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module tcw_screen_ram #(
  parameter int DEPTH = 2000,
  parameter int AW    = 11,
  parameter int DW    = 16
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
